[src/lhp_pkg.sv]
`default_nettype none
package lhp_pkg;

    localparam int NUM_BUCKETS = 23;
    localparam int IDX_W       = 5;
    localparam int ACC_W       = 38;
    localparam int TGT_W       = 33;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);

    typedef struct packed {
        logic             vld;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [ACC_W-1:0] acc;
    } t_walk;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [31:0] bucket_bound(input logic [IDX_W-1:0] idx);
        logic [31:0] b;
        case (idx)
            5'd0:    b = 32'd10;
            5'd1:    b = 32'd20;
            5'd2:    b = 32'd30;
            5'd3:    b = 32'd40;
            5'd4:    b = 32'd50;
            5'd5:    b = 32'd60;
            5'd6:    b = 32'd70;
            5'd7:    b = 32'd80;
            5'd8:    b = 32'd90;
            5'd9:    b = 32'd100;
            5'd10:   b = 32'd200;
            5'd11:   b = 32'd300;
            5'd12:   b = 32'd400;
            5'd13:   b = 32'd500;
            5'd14:   b = 32'd600;
            5'd15:   b = 32'd700;
            5'd16:   b = 32'd800;
            5'd17:   b = 32'd900;
            5'd18:   b = 32'd1000;
            5'd19:   b = 32'd2000;
            5'd20:   b = 32'd5000;
            5'd21:   b = 32'd10000;
            default: b = 32'hFFFF_FFFF;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[src/lhp_cell.sv]
`default_nettype none
module lhp_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [lhp_pkg::IDX_W-1:0] i_idx,
    input  wire logic                      i_rec,
    input  wire logic [31:0]               i_latency_ns,
    input  wire logic [lhp_pkg::TGT_W-1:0] i_target,
    input  wire lhp_pkg::t_walk            i_walk,
    output lhp_pkg::t_walk                 o_walk
);
    import lhp_pkg::*;

    logic [31:0]      r_count;
    logic [31:0]      n_count;
    t_walk            r_walk;
    t_walk            n_walk;
    logic             hit;
    logic             above_lo;
    logic             below_hi;
    logic [ACC_W-1:0] acc_sum;

    assign above_lo = (i_idx == '0) || (i_latency_ns > bucket_bound(i_idx - IDX_W'(1)));
    assign below_hi = (i_idx == LAST_IDX) || (i_latency_ns <= bucket_bound(i_idx));
    assign hit      = i_rec && above_lo && below_hi;
    assign acc_sum  = i_walk.acc + ACC_W'(r_count);

    always_comb begin
        n_count = r_count;
        if (hit && r_count != 32'hFFFF_FFFF) begin
            n_count = r_count + 32'd1;
        end
        n_walk     = i_walk;
        n_walk.acc = acc_sum;
        if (!i_walk.found && acc_sum >= ACC_W'(i_target)) begin
            n_walk.found = 1'b1;
            n_walk.idx   = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_walk.vld <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_walk.vld <= n_walk.vld;
        end
        r_walk.found <= n_walk.found;
        r_walk.idx   <= n_walk.idx;
        r_walk.acc   <= n_walk.acc;
    end

    assign o_walk = r_walk;

endmodule
`default_nettype wire

[src/latency_histogram_percentile_unit.sv]
`default_nettype none
// Latency histogram with percentile query.
// The request channel (i_valid, o_ready) carries i_req_type, i_latency_ns and
// i_fraction_q16. A record request adds one sample and gives no response.
// A query request returns one response on (o_valid, i_ready) with the
// percentile bound and the current count, sum and peak.
// Records are taken one per cycle while no query is in progress.
// A query moves from acceptance to o_valid in steps: the 17 x 32 target
// multiply, the launch of the walk, and the walk itself, in which the
// running cumulative sum moves along the 23-cell chain one bucket cell
// at a time. During that time o_ready is low. The next request is taken
// as soon as the response has been loaded into the output register.
// If the receiver stalls, the response waits in the output register and a
// finished query holds until that register is free.
// Reset clears all bucket counts, the sample count, the sum and the peak.
module latency_histogram_percentile_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_latency_ns,
    input  wire logic [16:0] i_fraction_q16,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_percentile_ns,
    output logic [31:0]      o_sample_count,
    output logic [47:0]      o_latency_total,
    output logic [31:0]      o_latency_peak
);
    import lhp_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [31:0]      r_samples;
    logic [47:0]      r_sum;
    logic [31:0]      r_peak;
    logic [16:0]      r_frac;
    logic [TGT_W-1:0] r_target;
    logic             r_launch;
    logic [31:0]      r_pct;
    logic             r_o_valid;
    logic [31:0]      r_o_pct;
    logic [31:0]      r_o_cnt;
    logic [47:0]      r_o_sum;
    logic [31:0]      r_o_peak;
    logic             accept;
    logic             rec;
    logic             load;
    logic [48:0]      sum_ext;
    logic [48:0]      product;
    logic [31:0]      pct;
    t_walk            w [NUM_BUCKETS+1];

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign rec     = accept && !i_req_type;
    assign load    = (r_state == S_DONE) && (!r_o_valid || i_ready);
    assign sum_ext = {1'b0, r_sum} + {17'd0, i_latency_ns};
    assign product = 49'(r_frac) * 49'(r_samples);

    always_comb begin
        w[0].vld   = r_launch;
        w[0].found = 1'b0;
        w[0].idx   = '0;
        w[0].acc   = '0;
    end

    for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_cell
        lhp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_idx        (IDX_W'(g)),
            .i_rec        (rec),
            .i_latency_ns (i_latency_ns),
            .i_target     (r_target),
            .i_walk       (w[g]),
            .o_walk       (w[g+1])
        );
    end

    always_comb begin
        if (r_samples == '0) begin
            pct = '0;
        end else if (w[NUM_BUCKETS].found && w[NUM_BUCKETS].idx != LAST_IDX) begin
            pct = bucket_bound(w[NUM_BUCKETS].idx);
        end else begin
            pct = r_peak;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && i_req_type) n_state = S_MUL;
            S_MUL:  n_state = S_WALK;
            S_WALK: if (w[NUM_BUCKETS].vld) n_state = S_DONE;
            S_DONE: if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_samples <= '0;
            r_sum     <= '0;
            r_peak    <= '0;
            r_launch  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= (r_state == S_MUL);
            if (rec) begin
                if (r_samples != 32'hFFFF_FFFF) begin
                    r_samples <= r_samples + 32'd1;
                end
                r_sum <= sum_ext[48] ? 48'hFFFF_FFFF_FFFF : sum_ext[47:0];
                if (i_latency_ns > r_peak) begin
                    r_peak <= i_latency_ns;
                end
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_frac <= i_fraction_q16;
        end
        if (r_state == S_MUL) begin
            r_target <= product[48:16];
        end
        if (r_state == S_WALK && w[NUM_BUCKETS].vld) begin
            r_pct <= pct;
        end
        if (load) begin
            r_o_pct  <= r_pct;
            r_o_cnt  <= r_samples;
            r_o_sum  <= r_sum;
            r_o_peak <= r_peak;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_percentile_ns = r_o_pct;
    assign o_sample_count  = r_o_cnt;
    assign o_latency_total = r_o_sum;
    assign o_latency_peak  = r_o_peak;

`ifndef SYNTHESIS
    a_walk_end_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w[NUM_BUCKETS].vld |-> r_state == S_WALK)
        else $error("walk result arrived outside the walk state");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sample_count == '0) |-> o_percentile_ns == '0)
        else $error("nonzero percentile with no samples");

    a_peak_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_peak >= $past(r_peak))
        else $error("peak decreased");

    a_launch_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> r_launch && r_state == S_WALK)
        else $error("walk not launched after target multiply");
`endif

endmodule
`default_nettype wire
